// ===== hw/rtl/stl_pkg.sv =====
// package: lexer types, codes and a helper function
package stl_pkg;

    localparam int MaxTokenLen = 256;
    localparam int LenW = $clog2(MaxTokenLen + 1);

    // lexer modes
    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_STRING  = 4'd1;
    localparam logic [3:0] M_SIGN    = 4'd2;
    localparam logic [3:0] M_INT     = 4'd3;
    localparam logic [3:0] M_DEC     = 4'd4;
    localparam logic [3:0] M_SYM     = 4'd5;
    localparam logic [3:0] M_HASH    = 4'd6;
    localparam logic [3:0] M_COMMENT = 4'd7;
    localparam logic [3:0] M_ERROR   = 4'd8;

    // event codes
    localparam logic [1:0] EV_TEXT  = 2'd0;
    localparam logic [1:0] EV_DONE  = 2'd1;
    localparam logic [1:0] EV_ERR   = 2'd2;
    localparam logic [1:0] EV_END   = 2'd3;

    // token kinds
    localparam logic [2:0] K_OPEN  = 3'd0;
    localparam logic [2:0] K_CLOSE = 3'd1;
    localparam logic [2:0] K_STR   = 3'd2;
    localparam logic [2:0] K_INT   = 3'd3;
    localparam logic [2:0] K_DEC   = 3'd4;
    localparam logic [2:0] K_BOOL  = 3'd5;
    localparam logic [2:0] K_SYM   = 3'd6;

    // error codes
    localparam logic [2:0] E_STR   = 3'd0;
    localparam logic [2:0] E_NUM   = 3'd1;
    localparam logic [2:0] E_DEC   = 3'd2;
    localparam logic [2:0] E_SYM   = 3'd3;
    localparam logic [2:0] E_BOOL  = 3'd4;
    localparam logic [2:0] E_CHAR  = 3'd5;
    localparam logic [2:0] E_LONG  = 3'd6;

    localparam logic [31:0] SatMag = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [2:0]  token_kind;
        logic [7:0]  text_byte;
        logic        first_byte;
        logic [31:0] int_value;
        logic [2:0]  error_code;
        logic        last;
    } t_res;

    // one input item after classification
    typedef struct packed {
        logic [7:0] b;
        logic       eoi;
        logic       digit;
        logic       space;
        logic       paren;
        logic       sym_start;
        logic       sym_more;
    } t_cls;

    function automatic logic f_sym_start(input logic [7:0] b);
        return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122) ||
               b == "!" || b == "$" || b == "%" || b == "&" || b == "*" ||
               b == "/" || b == ":" || b == "<" || b == "=" || b == ">" ||
               b == "?" || b == "~" || b == "_" || b == "^";
    endfunction

endpackage

// ===== hw/rtl/stl_if.sv =====
// valid/ready channel interfaces
interface stl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] input_byte;
    logic       end_of_input;
    modport source (output valid, input ready, output input_byte, output end_of_input);
    modport sink   (input valid, output ready, input input_byte, input end_of_input);
endinterface

interface stl_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        event_res;
    logic [2:0]        token_kind;
    logic [7:0]        text_byte;
    logic              first_byte;
    logic signed [31:0] int_value;
    logic [2:0]        error_code;
    logic              last;
    modport source (output valid, input ready, output event_res, output token_kind,
                    output text_byte, output first_byte, output int_value,
                    output error_code, output last);
    modport sink   (input valid, output ready, input event_res, input token_kind,
                    input text_byte, input first_byte, input int_value,
                    input error_code, input last);
endinterface

// ===== hw/rtl/scheme_token_lexer.sv =====
// top level: scheme token lexer
//   channel   dir   payload
//   i_in      in    input_byte, end_of_input
//   o_out     out   event_res, token_kind, text_byte, first_byte, int_value,
//                   error_code, last
// a byte makes up to three results; the back end state machine emitting one
// result a cycle while the output is ready sets the rate. a two-entry queue
// decouples input from the back end.
// synchronous active-low reset returns the lexer to idle; either side may stall.
module scheme_token_lexer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stl_in_if.sink    i_in,
    stl_out_if.source o_out
);
    logic          q_valid, q_ready;
    stl_pkg::t_cls q_cls;

    stl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .o_valid(q_valid), .i_ready(q_ready), .o_cls(q_cls)
    );

    stl_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_ready(q_ready),
        .i_cls(q_cls), .o_out(o_out)
    );
endmodule

// ===== hw/rtl/stl_front.sv =====
// front end: accepts bytes, classifies them, two-entry queue to the back end
module stl_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    stl_in_if.sink               i_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output stl_pkg::t_cls        o_cls
);
    stl_pkg::t_cls r_q [2];
    logic [1:0]    r_cnt;
    logic          r_rd;
    logic          push, pop;
    stl_pkg::t_cls c;

    // classify
    always_comb begin
        c.b         = i_in.input_byte;
        c.eoi       = i_in.end_of_input;
        c.digit     = i_in.input_byte >= 8'd48 && i_in.input_byte <= 8'd57;
        c.space     = i_in.input_byte == " " || i_in.input_byte == 8'h0a;
        c.paren     = i_in.input_byte == "(" || i_in.input_byte == ")";
        c.sym_start = stl_pkg::f_sym_start(i_in.input_byte);
        c.sym_more  = c.sym_start || c.digit || i_in.input_byte == "+" ||
                      i_in.input_byte == "-" || i_in.input_byte == ".";
    end

    assign i_in.ready = r_cnt != 2'd2;
    assign push       = i_in.valid && i_in.ready;
    assign o_valid    = r_cnt != 2'd0;
    assign pop        = o_valid && i_ready;
    assign o_cls      = r_q[r_rd];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_rd ^ (r_cnt == 2'd1 ? 1'b1 : 1'b0) ^ (pop ? 1'b1 : 1'b0) ^
                      (pop ? 1'b1 : 1'b0)] <= c;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (pop) r_rd <= ~r_rd;
        end
    end
endmodule

// ===== hw/rtl/stl_back.sv =====
// back end: lexer state machine, up to three results per byte, one result per cycle while the output is ready
module stl_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  stl_pkg::t_cls i_cls,
    stl_out_if.source     o_out
);
    localparam int LW = stl_pkg::LenW;

    logic [3:0]    r_mode;
    logic [7:0]    r_sign;
    logic          r_point;
    logic [31:0]   r_acc;
    logic          r_neg;
    logic [LW-1:0] r_len;

    // result list of the current byte
    stl_pkg::t_res r_buf [3];
    logic [1:0]    r_num;
    logic [1:0]    r_idx;
    logic          r_busy;

    // output register
    stl_pkg::t_res r_o;
    logic          r_ov;

    // next-state computation
    logic [3:0]    n_mode;
    logic [7:0]    n_sign;
    logic          n_point;
    logic [31:0]   n_acc;
    logic          n_neg;
    logic [LW-1:0] n_len;
    stl_pkg::t_res n_buf [3];
    logic [1:0]    n_num;
    logic          stop;
    logic [35:0]   prod;
    logic [31:0]   dacc;
    logic [31:0]   ires;
    logic [7:0]    b;
    logic          take, oload;

    // digit accumulate on the current byte, and the saturated signed integer result
    always_comb begin
        prod = {4'd0, r_acc} * 36'd10 + {28'd0, b - 8'd48};
        dacc = prod > {4'd0, stl_pkg::SatMag} ? stl_pkg::SatMag : prod[31:0];
        ires = r_neg ? 32'd0 - r_acc : (r_acc > 32'h7fff_ffff ? 32'h7fff_ffff : r_acc);
    end

    always_comb begin
        b = i_cls.b;
        n_mode = r_mode; n_sign = r_sign; n_point = r_point; n_acc = r_acc;
        n_neg = r_neg; n_len = r_len; n_num = 2'd0; stop = 1'b0;
        for (int i = 0; i < 3; i++) n_buf[i] = '0;

        if (i_cls.eoi) begin
            case (r_mode)
                stl_pkg::M_STRING: begin
                    n_buf[n_num].event_res = stl_pkg::EV_ERR;
                    n_buf[n_num].error_code = stl_pkg::E_STR; n_num = n_num + 2'd1;
                end
                stl_pkg::M_INT: begin
                    n_buf[n_num].event_res = stl_pkg::EV_DONE;
                    n_buf[n_num].token_kind = stl_pkg::K_INT;
                    n_buf[n_num].int_value = ires; n_num = n_num + 2'd1;
                end
                stl_pkg::M_DEC, stl_pkg::M_SYM: begin
                    n_buf[n_num].event_res = stl_pkg::EV_DONE;
                    n_buf[n_num].token_kind = (r_mode == stl_pkg::M_DEC) ?
                                              stl_pkg::K_DEC : stl_pkg::K_SYM;
                    n_num = n_num + 2'd1;
                end
                stl_pkg::M_SIGN: begin
                    if (!r_point) begin
                        n_buf[0].event_res = stl_pkg::EV_TEXT;
                        n_buf[0].token_kind = stl_pkg::K_SYM;
                        n_buf[0].text_byte = r_sign;
                        n_buf[0].first_byte = 1'b1;
                        n_buf[1].event_res = stl_pkg::EV_DONE;
                        n_buf[1].token_kind = stl_pkg::K_SYM;
                        n_num = 2'd2;
                    end else begin
                        n_buf[0].event_res = stl_pkg::EV_ERR;
                        n_buf[0].error_code = (r_sign != 8'd0) ? stl_pkg::E_SYM :
                                                                 stl_pkg::E_DEC;
                        n_num = 2'd1;
                    end
                end
                stl_pkg::M_HASH: begin
                    n_buf[0].event_res = stl_pkg::EV_ERR;
                    n_buf[0].error_code = stl_pkg::E_BOOL; n_num = 2'd1;
                end
                default: ;
            endcase
            n_buf[n_num].event_res = stl_pkg::EV_END;
            n_num = n_num + 2'd1;
            n_mode = stl_pkg::M_IDLE; n_sign = '0; n_point = 1'b0;
            n_acc = '0; n_neg = 1'b0; n_len = '0;
        end else begin
            logic       st;      // start-byte processing needed
            logic       clo;     // completion of current token before start
            logic [2:0] ck;
            logic [31:0] cv;
            logic [LW-1:0] len;
            logic       failed;
            logic [2:0] fcode;
            logic [7:0] tb [3];
            logic [1:0] nt;      // text bytes to emit
            logic [2:0] tk;
            st = 1'b0; clo = 1'b0; ck = '0; cv = '0; failed = 1'b0; fcode = '0;
            tb[0] = '0; tb[1] = '0; tb[2] = '0; nt = 2'd0; tk = '0;
            len = r_len;
            case (r_mode)
                stl_pkg::M_IDLE: st = 1'b1;
                stl_pkg::M_STRING: begin
                    nt = 2'd1; tk = stl_pkg::K_STR; tb[0] = b;
                end
                stl_pkg::M_INT: begin
                    if (i_cls.digit) begin nt = 2'd1; tk = stl_pkg::K_INT; tb[0] = b; end
                    else if (b == ".") begin nt = 2'd1; tk = stl_pkg::K_DEC; tb[0] = b; end
                    else if (i_cls.space || i_cls.paren) begin
                        clo = 1'b1; ck = stl_pkg::K_INT; cv = ires;
                    end else begin failed = 1'b1; fcode = stl_pkg::E_NUM; end
                end
                stl_pkg::M_DEC: begin
                    if (i_cls.digit) begin nt = 2'd1; tk = stl_pkg::K_DEC; tb[0] = b; end
                    else if (i_cls.space || i_cls.paren) begin
                        clo = 1'b1; ck = stl_pkg::K_DEC;
                    end else begin failed = 1'b1; fcode = stl_pkg::E_DEC; end
                end
                stl_pkg::M_SYM: begin
                    if (i_cls.sym_more) begin nt = 2'd1; tk = stl_pkg::K_SYM; tb[0] = b; end
                    else if (i_cls.space || i_cls.paren) begin
                        clo = 1'b1; ck = stl_pkg::K_SYM;
                    end else begin failed = 1'b1; fcode = stl_pkg::E_SYM; end
                end
                stl_pkg::M_SIGN: begin
                    if (!r_point) begin
                        if (i_cls.space || i_cls.paren) begin
                            nt = 2'd1; tk = stl_pkg::K_SYM; tb[0] = r_sign;
                            clo = 1'b1; ck = stl_pkg::K_SYM;
                        end else if (i_cls.digit) begin
                            nt = 2'd2; tk = stl_pkg::K_INT; tb[0] = r_sign; tb[1] = b;
                        end else if (b == ".") begin
                            n_point = 1'b1;
                        end else begin failed = 1'b1; fcode = stl_pkg::E_SYM; end
                    end else if (i_cls.digit) begin
                        tk = stl_pkg::K_DEC;
                        if (r_sign != 8'd0) begin
                            nt = 2'd3; tb[0] = r_sign; tb[1] = "."; tb[2] = b;
                        end else begin
                            nt = 2'd2; tb[0] = "."; tb[1] = b;
                        end
                    end else begin
                        failed = 1'b1;
                        fcode = (r_sign != 8'd0) ? stl_pkg::E_SYM : stl_pkg::E_DEC;
                    end
                end
                stl_pkg::M_HASH: begin
                    if (b == "t" || b == "f") begin
                        nt = 2'd2; tk = stl_pkg::K_BOOL; tb[0] = "#"; tb[1] = b;
                        clo = 1'b1; ck = stl_pkg::K_BOOL;
                        cv = (b == "t") ? 32'd1 : 32'd0;
                    end else begin failed = 1'b1; fcode = stl_pkg::E_BOOL; end
                end
                stl_pkg::M_COMMENT: if (b == 8'h0a) n_mode = stl_pkg::M_IDLE;
                stl_pkg::M_ERROR: ;
                default: begin
                    n_mode = stl_pkg::M_IDLE; n_sign = '0; n_point = 1'b0;
                    n_acc = '0; n_neg = 1'b0; n_len = '0;
                end
            endcase

            // emit text bytes with length check
            for (int i = 0; i < 3; i++) begin
                if (!stop && i < int'(nt)) begin
                    if (len >= LW'(stl_pkg::MaxTokenLen)) begin
                        failed = 1'b1; fcode = stl_pkg::E_LONG;
                        stop = 1'b1;
                    end else begin
                        n_buf[n_num].event_res = stl_pkg::EV_TEXT;
                        n_buf[n_num].token_kind = tk;
                        n_buf[n_num].text_byte = tb[i];
                        n_buf[n_num].first_byte = (len == '0);
                        n_num = n_num + 2'd1;
                        len = len + LW'(1);
                    end
                end
            end
            n_len = len;
            if (failed) begin
                clo = 1'b0; st = 1'b0;
            end else begin
                // mode updates for successful text
                case (r_mode)
                    stl_pkg::M_STRING: if (b == "\"") begin
                        clo = 1'b1; ck = stl_pkg::K_STR;
                    end
                    stl_pkg::M_INT: if (i_cls.digit) n_acc = dacc;
                        else if (b == ".") n_mode = stl_pkg::M_DEC;
                    stl_pkg::M_SIGN: if (!r_point && i_cls.digit) begin
                        n_neg = (r_sign == "-"); n_acc = dacc; n_mode = stl_pkg::M_INT;
                    end else if (r_point && i_cls.digit) n_mode = stl_pkg::M_DEC;
                    default: ;
                endcase
            end
            if (clo) begin
                n_buf[n_num].event_res = stl_pkg::EV_DONE;
                n_buf[n_num].token_kind = ck;
                n_buf[n_num].int_value = cv;
                n_num = n_num + 2'd1;
                n_mode = stl_pkg::M_IDLE; n_sign = '0; n_point = 1'b0;
                n_acc = '0; n_neg = 1'b0; n_len = '0;
                if (i_cls.paren && r_mode != stl_pkg::M_HASH &&
                    r_mode != stl_pkg::M_STRING) st = 1'b1;
            end
            // start-of-token byte
            if (st) begin
                if (i_cls.paren) begin
                    n_buf[n_num].event_res = stl_pkg::EV_DONE;
                    n_buf[n_num].token_kind = (b == "(") ? stl_pkg::K_OPEN :
                                                           stl_pkg::K_CLOSE;
                    n_num = n_num + 2'd1;
                    n_mode = stl_pkg::M_IDLE;
                end else if (b == "\"" || i_cls.digit || i_cls.sym_start) begin
                    if (r_len >= LW'(stl_pkg::MaxTokenLen)) begin
                        failed = 1'b1; fcode = stl_pkg::E_LONG;
                    end else begin
                        n_buf[n_num].event_res = stl_pkg::EV_TEXT;
                        n_buf[n_num].token_kind = (b == "\"") ? stl_pkg::K_STR :
                            (i_cls.digit ? stl_pkg::K_INT : stl_pkg::K_SYM);
                        n_buf[n_num].text_byte = b;
                        n_buf[n_num].first_byte = 1'b1;
                        n_num = n_num + 2'd1;
                        n_len = LW'(1);
                        n_mode = (b == "\"") ? stl_pkg::M_STRING :
                                 (i_cls.digit ? stl_pkg::M_INT : stl_pkg::M_SYM);
                        if (i_cls.digit) n_acc = dacc;
                    end
                end else if (b == "+" || b == "-") begin
                    n_sign = b; n_point = 1'b0; n_mode = stl_pkg::M_SIGN;
                end else if (b == ".") begin
                    n_sign = '0; n_point = 1'b1; n_mode = stl_pkg::M_SIGN;
                end else if (b == "#") n_mode = stl_pkg::M_HASH;
                else if (b == ";") n_mode = stl_pkg::M_COMMENT;
                else if (!i_cls.space) begin
                    failed = 1'b1; fcode = stl_pkg::E_CHAR;
                end
            end
            if (failed) begin
                n_buf[n_num].event_res = stl_pkg::EV_ERR;
                n_buf[n_num].error_code = fcode;
                n_num = n_num + 2'd1;
                n_mode = stl_pkg::M_ERROR; n_sign = '0; n_point = 1'b0;
                n_acc = '0; n_neg = 1'b0; n_len = '0;
            end
        end
        if (n_num != 2'd0) n_buf[n_num - 2'd1].last = 1'b1;
    end

    // take a new byte when the result list is drained or finishing now
    assign oload   = r_busy && (!r_ov || o_out.ready);
    assign o_ready = !r_busy || (oload && r_idx == r_num - 2'd1);
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_buf[0] <= n_buf[0]; r_buf[1] <= n_buf[1]; r_buf[2] <= n_buf[2];
            r_num <= n_num;
        end
        if (oload) r_o <= r_buf[r_idx];
    end

    // lexer state and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= stl_pkg::M_IDLE; r_sign <= '0; r_point <= 1'b0;
            r_acc <= '0; r_neg <= 1'b0; r_len <= '0;
            r_busy <= 1'b0; r_idx <= '0; r_ov <= 1'b0;
        end else begin
            if (take) begin
                r_mode <= n_mode; r_sign <= n_sign; r_point <= n_point;
                r_acc <= n_acc; r_neg <= n_neg; r_len <= n_len;
            end
            if (oload) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
            if (take) begin
                r_busy <= n_num != 2'd0;
                r_idx  <= '0;
            end else if (oload) begin
                if (r_idx == r_num - 2'd1) r_busy <= 1'b0;
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.event_res  = r_o.event_res;
    assign o_out.token_kind = r_o.token_kind;
    assign o_out.text_byte  = r_o.text_byte;
    assign o_out.first_byte = r_o.first_byte;
    assign o_out.int_value  = r_o.int_value;
    assign o_out.error_code = r_o.error_code;
    assign o_out.last       = r_o.last;
endmodule
